[design/multi_servo_pulse_sequencer_assert.svh]
// ----------------------------------------------------------------------------
// multi_servo_pulse_sequencer assertion macros
// Concurrent assertion shorthands shared by the sequencer RTL; they expand
// to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef MULTI_SERVO_PULSE_SEQUENCER_ASSERT_SVH
`define MULTI_SERVO_PULSE_SEQUENCER_ASSERT_SVH
`ifndef SYNTH
// condition holds at every edge out of reset
`define MSPS_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("msps invariant violated");
// consequent holds in the same cycle as the antecedent
`define MSPS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("msps implication violated");
// consequent holds in the cycle after the antecedent
`define MSPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("msps next-cycle check violated");
`else
`define MSPS_ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define MSPS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define MSPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[design/msps_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msps_pkg
// Shared constants, register map, configuration struct and state type of the
// multi-servo pulse sequencer.
// ----------------------------------------------------------------------------
package msps_pkg;

	// channel count and derived slot geometry
	localparam int NUM_CHANNELS = 8;
	localparam int IDLE_SLOT    = NUM_CHANNELS;
	localparam int NUM_SLOTS    = NUM_CHANNELS + 1;
	localparam int CH_W         = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int SLOT_AW      = $clog2(NUM_SLOTS);

	// datapath widths
	localparam int VAL_W  = 15;
	localparam int LEN_W  = 16;
	localparam int SUM_W  = 20;
	localparam int PROD_W = VAL_W + LEN_W;

	// apb port
	localparam int APB_AW = 5;
	localparam int APB_DW = 32;

	// command value of a channel never written since reset
	localparam logic [VAL_W-1:0] CV_RESET = 15'd500;

	// register reset values
	localparam logic [14:0] VALUE_MAX_RST   = 15'd1000;
	localparam logic [15:0] PULSE_MIN_RST   = 16'd1800;
	localparam logic [15:0] PULSE_MAX_RST   = 16'd4800;
	localparam logic [15:0] UNIT_Q8_RST     = 16'd768;
	localparam logic [15:0] FRAME_TICKS_RST = 16'd40000;
	localparam logic [7:0]  CH_ENABLE_RST   = 8'hFF;

	// register index, word address = 4 * index
	typedef enum logic [2:0] {
		REG_VALUE_MAX   = 3'd0,
		REG_PULSE_MIN   = 3'd1,
		REG_PULSE_MAX   = 3'd2,
		REG_UNIT_Q8     = 3'd3,
		REG_FRAME_TICKS = 3'd4,
		REG_CH_ENABLE   = 3'd5
	} reg_idx_t;

	// input word kinds carried on tuser
	typedef enum logic [1:0] {
		FUNC_TICK = 2'd0,
		FUNC_SET  = 2'd1,
		FUNC_ADD  = 2'd2
	} func_t;

	// configuration handed from the register file to the sequencer
	typedef struct packed {
		logic [14:0] value_max;
		logic [15:0] pulse_min;
		logic [15:0] pulse_max;
		logic [15:0] unit_q8;
		logic [15:0] frame_ticks;
		logic [7:0]  channel_enable;
	} cfg_t;

	// sequencer control states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WR_MOD,
		ST_REC_RD,
		ST_REC_MUL,
		ST_REC_ACC,
		ST_REC_IDLE,
		ST_BND_RD,
		ST_BND_LD,
		ST_OUT
	} state_t;

endpackage
`default_nettype wire

[design/msps_regs.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msps_regs
// APB configuration register file of the servo pulse sequencer: six
// registers at word addresses, writes in the access phase, zero-wait reads.
// ----------------------------------------------------------------------------
module msps_regs import msps_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t       cfg_q;
	logic [2:0] reg_idx;
	logic       wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign wr_en   = psel && penable && pwrite && pready;
	assign cfg     = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.value_max      <= VALUE_MAX_RST;
			cfg_q.pulse_min      <= PULSE_MIN_RST;
			cfg_q.pulse_max      <= PULSE_MAX_RST;
			cfg_q.unit_q8        <= UNIT_Q8_RST;
			cfg_q.frame_ticks    <= FRAME_TICKS_RST;
			cfg_q.channel_enable <= CH_ENABLE_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_VALUE_MAX:   cfg_q.value_max      <= pwdata[14:0];
				REG_PULSE_MIN:   cfg_q.pulse_min      <= pwdata[15:0];
				REG_PULSE_MAX:   cfg_q.pulse_max      <= pwdata[15:0];
				REG_UNIT_Q8:     cfg_q.unit_q8        <= pwdata[15:0];
				REG_FRAME_TICKS: cfg_q.frame_ticks    <= pwdata[15:0];
				REG_CH_ENABLE:   cfg_q.channel_enable <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		case (reg_idx)
			REG_VALUE_MAX:   prdata = {17'd0, cfg_q.value_max};
			REG_PULSE_MIN:   prdata = {16'd0, cfg_q.pulse_min};
			REG_PULSE_MAX:   prdata = {16'd0, cfg_q.pulse_max};
			REG_UNIT_Q8:     prdata = {16'd0, cfg_q.unit_q8};
			REG_FRAME_TICKS: prdata = {16'd0, cfg_q.frame_ticks};
			REG_CH_ENABLE:   prdata = {24'd0, cfg_q.channel_enable};
			default:         prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

[design/multi_servo_pulse_sequencer.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multi_servo_pulse_sequencer
// Eight-channel RC servo pulse sequencer: runs one channel pulse slot after
// another plus an idle gap per frame, driven by timer tick words.
// ----------------------------------------------------------------------------
// Usage: each input word (tick, set value, add delta; kind on s_tuser) gives
// exactly one output word with the pin levels, running slot, the stored value
// after a write and the overrun flag. One word is in flight at a time: a tick
// that does not end a slot goes straight to output, a channel write reads,
// modifies and writes back the command memory, a slot boundary reads the
// pulse length memory, and the idle-slot boundary after reset or a change of
// command values first runs the recompute loop that takes the eight channels
// through one shared 15x16 multiplier by read, multiply and accumulate steps.
// The output register lets the next word be taken while a result waits.
// No clearing pass after reset: command values read as 500 until written.
// ----------------------------------------------------------------------------
`include "multi_servo_pulse_sequencer_assert.svh"
module multi_servo_pulse_sequencer import msps_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	// configuration port
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	// input words
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [23:0]       s_tdata,  // channel[3:0], units[19:4], zero[23:20]
	input  logic [1:0]        s_tuser,  // func[1:0]
	// result words
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [31:0]       m_tdata   // pins[7:0], slot[11:8],
	                                    // channel_value[26:12], overrun[27]
);

	cfg_t cfg;

	msps_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	state_t state_q, state_d;

	// item latched at accept
	logic [CH_W-1:0]    ch_q;
	logic signed [15:0] units_q;
	logic               is_add_q;
	logic [SLOT_AW-1:0] slot_q;

	// sequencer state
	logic [SLOT_AW-1:0] next_q;
	logic [SLOT_AW-1:0] running_q;
	logic [LEN_W-1:0]   ticks_q;
	logic               changed_q;
	logic [7:0]         pins_q;
	logic               overrun_q;
	logic [VAL_W-1:0]   cv_q;
	logic [NUM_CHANNELS-1:0] cv_valid_q;

	// recompute loop
	logic [CH_W-1:0]    idx_q;
	logic [SUM_W-1:0]   sum_q;
	logic [PROD_W-1:0]  prod_q;

	// memories
	logic [VAL_W-1:0]   cv_mem [NUM_CHANNELS];
	logic [LEN_W-1:0]   len_mem [NUM_SLOTS];
	logic [VAL_W-1:0]   cv_rdata_q;
	logic               cv_hit_q;
	logic [LEN_W-1:0]   len_rdata_q;

	// output register
	logic               out_valid_q;
	logic [31:0]        out_data_q;

	// strobes
	logic               cv_rd_en, cv_wr_en, len_rd_en, len_wr_en;
	logic [CH_W-1:0]    cv_rd_addr;
	logic [SLOT_AW-1:0] len_wr_addr;
	logic [LEN_W-1:0]   len_wr_data;
	logic               out_load;

	// input decode
	logic               acc;
	logic [3:0]         in_ch;
	logic signed [15:0] in_units;
	logic               ch_ok;
	logic [SLOT_AW-1:0] bnd_slot;
	logic               bnd_rec;

	assign acc      = s_tvalid && s_tready;
	assign in_ch    = s_tdata[3:0];
	assign in_units = $signed(s_tdata[19:4]);
	assign ch_ok    = {1'b0, in_ch} < 5'(NUM_CHANNELS);
	assign bnd_slot = (next_q > SLOT_AW'(IDLE_SLOT)) ? '0 : next_q;
	assign bnd_rec  = (bnd_slot == SLOT_AW'(IDLE_SLOT)) && changed_q;

	// channel write: clamp exact value to 0..value_max
	logic [VAL_W-1:0]   cv_eff;
	logic signed [17:0] v_sum;
	logic [VAL_W-1:0]   cv_new;

	assign cv_eff = cv_hit_q ? cv_rdata_q : CV_RESET;

	always_comb begin
		if (is_add_q) begin
			v_sum = $signed({3'b000, cv_eff}) + $signed({{2{units_q[15]}}, units_q});
		end else begin
			v_sum = $signed({{2{units_q[15]}}, units_q});
		end
		if (v_sum[17]) begin
			cv_new = '0;
		end else if (v_sum > $signed({3'b000, cfg.value_max})) begin
			cv_new = cfg.value_max;
		end else begin
			cv_new = v_sum[VAL_W-1:0];
		end
	end

	// pulse length: truncated scale plus offset, clamped
	logic [23:0]      p_sum;
	logic [LEN_W-1:0] len_calc;
	logic [SUM_W-1:0] sum_next;
	logic             sum_over;
	logic [LEN_W-1:0] idle_len;

	assign p_sum = {1'b0, prod_q[PROD_W-1:8]} + {8'd0, cfg.pulse_min};

	always_comb begin
		if (p_sum > {8'd0, cfg.pulse_max}) begin
			len_calc = (cfg.pulse_max < cfg.pulse_min) ? cfg.pulse_min : cfg.pulse_max;
		end else begin
			len_calc = p_sum[LEN_W-1:0];
		end
	end

	assign sum_next = sum_q + {4'd0, len_calc};
	assign sum_over = sum_q >= {4'd0, cfg.frame_ticks};
	assign idle_len = sum_over ? 16'd1 : (cfg.frame_ticks - sum_q[LEN_W-1:0]);

	// slot start: pin of an enabled channel slot
	logic [7:0] slot_x;
	logic [7:0] pin_set;
	logic [SLOT_AW-1:0] slot_after;

	assign slot_x     = 8'(slot_q);
	assign pin_set    = (slot_x < 8'(IDLE_SLOT) && slot_x < 8'd8 &&
	                     cfg.channel_enable[slot_x[2:0]]) ? (8'd1 << slot_x[2:0]) : 8'd0;
	assign slot_after = (slot_q >= SLOT_AW'(IDLE_SLOT)) ? '0 : slot_q + 1'b1;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and memory strobes
	always_comb begin
		state_d     = state_q;
		s_tready    = 1'b0;
		cv_rd_en    = 1'b0;
		cv_rd_addr  = in_ch[CH_W-1:0];
		cv_wr_en    = 1'b0;
		len_rd_en   = 1'b0;
		len_wr_en   = 1'b0;
		len_wr_addr = SLOT_AW'(idx_q);
		len_wr_data = len_calc;
		out_load    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cv_rd_en = 1'b1;
				if (acc) begin
					case (s_tuser)
						FUNC_TICK: begin
							if (ticks_q > 16'd1) begin
								state_d = ST_OUT;
							end else if (bnd_rec) begin
								state_d = ST_REC_RD;
							end else begin
								state_d = ST_BND_RD;
							end
						end
						FUNC_SET, FUNC_ADD: begin
							state_d = ch_ok ? ST_WR_MOD : ST_OUT;
						end
						default: state_d = ST_OUT;
					endcase
				end
			end
			ST_WR_MOD: begin
				cv_wr_en = 1'b1;
				state_d  = ST_OUT;
			end
			ST_REC_RD: begin
				cv_rd_en   = 1'b1;
				cv_rd_addr = idx_q;
				state_d    = ST_REC_MUL;
			end
			ST_REC_MUL: begin
				state_d = ST_REC_ACC;
			end
			ST_REC_ACC: begin
				len_wr_en = 1'b1;
				state_d   = (idx_q == CH_W'(NUM_CHANNELS - 1)) ? ST_REC_IDLE : ST_REC_RD;
			end
			ST_REC_IDLE: begin
				len_wr_en   = 1'b1;
				len_wr_addr = SLOT_AW'(IDLE_SLOT);
				len_wr_data = idle_len;
				state_d     = ST_BND_RD;
			end
			ST_BND_RD: begin
				len_rd_en = 1'b1;
				state_d   = ST_BND_LD;
			end
			ST_BND_LD: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!out_valid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// command value memory, one read port and one write port
	always_ff @(posedge clk) begin
		if (cv_rd_en) begin
			cv_rdata_q <= cv_mem[cv_rd_addr];
			cv_hit_q   <= cv_valid_q[cv_rd_addr];
		end
		if (cv_wr_en) begin
			cv_mem[ch_q] <= cv_new;
		end
	end

	// pulse length memory
	always_ff @(posedge clk) begin
		if (len_rd_en) begin
			len_rdata_q <= len_mem[slot_q];
		end
		if (len_wr_en) begin
			len_mem[len_wr_addr] <= len_wr_data;
		end
	end

	// item and loop payload
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					ch_q     <= in_ch[CH_W-1:0];
					units_q  <= in_units;
					is_add_q <= (s_tuser == FUNC_ADD);
					slot_q   <= bnd_slot;
					cv_q     <= '0;
					idx_q    <= '0;
					sum_q    <= '0;
				end
			end
			ST_WR_MOD: cv_q <= cv_new;
			ST_REC_MUL: prod_q <= {16'd0, cv_eff} * {15'd0, cfg.unit_q8};
			ST_REC_ACC: begin
				sum_q <= sum_next;
				idx_q <= idx_q + 1'b1;
			end
			default: ;
		endcase
	end

	// sequencer control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_q     <= SLOT_AW'(IDLE_SLOT);
			running_q  <= SLOT_AW'(IDLE_SLOT);
			ticks_q    <= 16'd1;
			changed_q  <= 1'b1;
			pins_q     <= '0;
			overrun_q  <= 1'b0;
			cv_valid_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (acc && s_tuser == FUNC_TICK) begin
						if (ticks_q > 16'd1) begin
							ticks_q <= ticks_q - 1'b1;
						end else if (bnd_rec) begin
							changed_q <= 1'b0;
						end
					end
				end
				ST_WR_MOD: begin
					cv_valid_q[ch_q] <= 1'b1;
					changed_q        <= 1'b1;
				end
				ST_REC_IDLE: overrun_q <= sum_over;
				ST_BND_LD: begin
					ticks_q   <= len_rdata_q;
					running_q <= slot_q;
					next_q    <= slot_after;
					pins_q    <= pin_set;
				end
				default: ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= {4'd0, overrun_q, cv_q, 4'(running_q), pins_q};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// checks
	logic [7:0] run_x;
	assign run_x = 8'(running_q);

	`MSPS_ASSERT_NEXT(a_one_item, clk, arst_n, s_tvalid && s_tready, !s_tready)
	`MSPS_ASSERT_ALWAYS(a_pins_onehot, clk, arst_n, $onehot0(pins_q))
	`MSPS_ASSERT_IMPL(a_pin_in_slot, clk, arst_n, pins_q != 8'd0, run_x < 8'(IDLE_SLOT) && pins_q == (8'd1 << run_x[2:0]))
	`MSPS_ASSERT_IMPL(a_idle_fresh, clk, arst_n, state_q == ST_BND_LD && slot_q == SLOT_AW'(IDLE_SLOT), !changed_q)

endmodule
`default_nettype wire

[verif/multi_servo_pulse_sequencer_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_servo_pulse_sequencer_tb
// Self-checking bench for the servo pulse sequencer. Tick, set and add words
// go in over the slave stream, and a behavioral model of the slot timing,
// the pulse length recompute and the value clamping predicts each status
// word. Register settings change between phases through the APB port, from
// directed corner settings to random small frames and a last extreme one.
// ----------------------------------------------------------------------------
module multi_servo_pulse_sequencer_tb;
	import msps_pkg::*;

	// func code with no operation behind it
	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	// one status word as the block reports it
	typedef struct packed {
		logic [7:0]       pins;
		logic [3:0]       slot;
		logic [VAL_W-1:0] cv;
		logic             overrun;
	} status_t;

	// frame model and queue of status words still to come
	class servo_frame_sb;
		cfg_t             setup;
		logic [VAL_W-1:0] cmd_val [NUM_CHANNELS];
		logic [LEN_W-1:0] slot_len [NUM_SLOTS];
		int unsigned      upcoming;
		int unsigned      running;
		logic [LEN_W-1:0] ticks_left;
		bit               dirty;
		logic [7:0]       pin_levels;
		bit               overrun_now;
		int               recomputes;
		int               errors;
		status_t          awaited [$];

		function new();
			setup = '{value_max: VALUE_MAX_RST, pulse_min: PULSE_MIN_RST,
				pulse_max: PULSE_MAX_RST, unit_q8: UNIT_Q8_RST,
				frame_ticks: FRAME_TICKS_RST, channel_enable: CH_ENABLE_RST};
			foreach (cmd_val[i]) cmd_val[i] = CV_RESET;
			foreach (slot_len[i]) slot_len[i] = '0;
			upcoming    = IDLE_SLOT;
			running     = IDLE_SLOT;
			ticks_left  = 1;
			dirty       = 1'b1;
			pin_levels  = '0;
			overrun_now = 1'b0;
			recomputes  = 0;
			errors      = 0;
		endfunction

		function void write_reg(input reg_idx_t idx, input logic [31:0] v);
			case (idx)
				REG_VALUE_MAX:   setup.value_max      = v[14:0];
				REG_PULSE_MIN:   setup.pulse_min      = v[15:0];
				REG_PULSE_MAX:   setup.pulse_max      = v[15:0];
				REG_UNIT_Q8:     setup.unit_q8        = v[15:0];
				REG_FRAME_TICKS: setup.frame_ticks    = v[15:0];
				REG_CH_ENABLE:   setup.channel_enable = v[7:0];
				default: ;
			endcase
		endfunction

		// advance the model by one accepted word and queue its status
		function void accept_command(input logic [1:0] f, input logic [3:0] ch,
				input logic [15:0] u);
			int unsigned      s;
			int               v;
			logic [19:0]      total;
			logic [31:0]      scaled;
			logic [23:0]      len;
			logic [VAL_W-1:0] stored;
			stored = '0;
			if (f == FUNC_TICK) begin
				if (ticks_left <= 1) begin
					// slot boundary: all pins drop, next slot starts
					s = upcoming;
					pin_levels = '0;
					if (s == IDLE_SLOT && dirty) begin
						// pulse lengths from the command table, idle fills the frame
						total = '0;
						for (int i = 0; i < NUM_CHANNELS; i++) begin
							scaled = (32'(cmd_val[i]) * 32'(setup.unit_q8)) >> 8;
							len = scaled[23:0] + 24'(setup.pulse_min);
							if (len > 24'(setup.pulse_max)) len = 24'(setup.pulse_max);
							if (len < 24'(setup.pulse_min)) len = 24'(setup.pulse_min);
							slot_len[i] = len[15:0];
							total += 20'(slot_len[i]);
						end
						if (total >= 20'(setup.frame_ticks)) begin
							slot_len[IDLE_SLOT] = 1;
							overrun_now = 1'b1;
						end else begin
							slot_len[IDLE_SLOT] = setup.frame_ticks - total[15:0];
							overrun_now = 1'b0;
						end
						dirty = 1'b0;
						recomputes++;
					end
					running = s;
					ticks_left = slot_len[s];
					if (s < IDLE_SLOT && setup.channel_enable[s]) pin_levels[s] = 1'b1;
					upcoming = (s >= IDLE_SLOT) ? 0 : s + 1;
				end else begin
					ticks_left--;
				end
			end else if ((f == FUNC_SET || f == FUNC_ADD) && ch < NUM_CHANNELS) begin
				// clamped write of the command table
				v = int'($signed(u));
				if (f == FUNC_ADD) v += int'(cmd_val[ch]);
				if (v > int'(setup.value_max)) v = int'(setup.value_max);
				if (v < 0) v = 0;
				stored = v[14:0];
				cmd_val[ch] = stored;
				dirty = 1'b1;
			end
			awaited.push_back('{pins: pin_levels, slot: 4'(running), cv: stored,
				overrun: overrun_now});
		endfunction

		task report_mismatch(input string msg);
			errors++;
			if (errors <= 100) $display("mismatch: %s", msg);
		endtask

		// compare one status word with the oldest prediction
		task check_status(input logic [31:0] w);
			status_t want;
			if (awaited.size() == 0) begin
				report_mismatch($sformatf("status word %h with none awaited", w));
				return;
			end
			want = awaited.pop_front();
			if (w[7:0] !== want.pins)
				report_mismatch($sformatf("pins %h, want %h", w[7:0], want.pins));
			if (w[11:8] !== want.slot)
				report_mismatch($sformatf("slot %0d, want %0d", w[11:8], want.slot));
			if (w[26:12] !== want.cv)
				report_mismatch($sformatf("channel_value %0d, want %0d", w[26:12], want.cv));
			if (w[27] !== want.overrun)
				report_mismatch($sformatf("overrun %b, want %b", w[27], want.overrun));
		endtask
	endclass

	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              psel     = 1'b0;
	logic              penable  = 1'b0;
	logic              pwrite   = 1'b0;
	logic [APB_AW-1:0] paddr    = '0;
	logic [APB_DW-1:0] pwdata   = '0;
	logic [APB_DW-1:0] prdata;
	logic              pready;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [23:0]       s_tdata  = '0;  // channel[3:0], units[19:4], zero[23:20]
	logic [1:0]        s_tuser  = '0;  // func[1:0]
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [31:0]       m_tdata;        // pins[7:0], slot[11:8],
	                                   // channel_value[26:12], overrun[27]

	servo_frame_sb sb;
	bit            sides_idle = 1'b0;
	int            stall_left = 0;

	multi_servo_pulse_sequencer i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #1 clk = ~clk;

	// receiver side with random stall bursts
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (sides_idle && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(0, 5);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// status word monitor
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check_status(m_tdata);
	end

	// send one word, called and returning at a falling edge
	task automatic push_word(input logic [1:0] f, input logic [3:0] ch,
			input logic [15:0] u);
		int gap;
		gap = (sides_idle && $urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= f;
		s_tdata  <= {4'b0, u, ch};
		do @(posedge clk); while (!s_tready);
		sb.accept_command(f, ch, u);
		@(negedge clk);
	endtask

	// hold the sender until every status word is back
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (sb.awaited.size() != 0);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= v;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.write_reg(idx, v);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	task automatic apply_setup(input cfg_t c);
		drain();
		write_reg(REG_VALUE_MAX, 32'(c.value_max));
		write_reg(REG_PULSE_MIN, 32'(c.pulse_min));
		write_reg(REG_PULSE_MAX, 32'(c.pulse_max));
		write_reg(REG_UNIT_Q8, 32'(c.unit_q8));
		write_reg(REG_FRAME_TICKS, 32'(c.frame_ticks));
		write_reg(REG_CH_ENABLE, 32'(c.channel_enable));
	endtask

	// tick until the idle slot has recomputed the pulse lengths
	task automatic run_to_recompute();
		int seen;
		seen = sb.recomputes;
		while (sb.recomputes == seen) push_word(FUNC_TICK, 4'($urandom), 16'($urandom));
	endtask

	// mostly ticks and in-range writes, some ignored writes and unused codes
	task automatic random_word();
		int          pick;
		int          d;
		logic [15:0] u;
		pick = $urandom_range(0, 99);
		if (pick == 0) drain();
		if ($urandom_range(0, 1) == 1) begin
			u = 16'($urandom);
		end else begin
			d = int'($urandom_range(0, 40)) - 20;
			u = 16'(d);
		end
		if (pick < 55) begin
			push_word(FUNC_TICK, 4'($urandom), 16'($urandom));
		end else if (pick < 70) begin
			if ($urandom_range(0, 1) == 1)
				u = 16'($urandom_range(0, int'(sb.setup.value_max) + 2));
			push_word(FUNC_SET, 4'($urandom_range(0, NUM_CHANNELS - 1)), u);
		end else if (pick < 88) begin
			push_word(FUNC_ADD, 4'($urandom_range(0, NUM_CHANNELS - 1)), u);
		end else if (pick < 96) begin
			push_word(($urandom_range(0, 1) == 1) ? FUNC_SET : FUNC_ADD,
				4'($urandom_range(NUM_CHANNELS, 15)), u);
		end else begin
			push_word(FUNC_UNUSED, 4'($urandom), u);
		end
	endtask

	initial begin
		cfg_t c;
		sb = new();
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		// clamping and ignored writes at the reset settings
		push_word(FUNC_SET, 4'd0, 16'h7FFF);
		push_word(FUNC_SET, 4'd1, 16'h8000);
		push_word(FUNC_SET, 4'd2, 16'd0);
		push_word(FUNC_SET, 4'd7, 16'd1000);
		push_word(FUNC_SET, 4'd6, 16'd1001);
		push_word(FUNC_ADD, 4'd3, 16'd1);
		push_word(FUNC_ADD, 4'd4, 16'h8000);
		push_word(FUNC_ADD, 4'd5, 16'h7FFF);
		push_word(FUNC_SET, 4'd8, 16'd123);
		push_word(FUNC_ADD, 4'd15, 16'hFFFF);
		push_word(FUNC_UNUSED, 4'd3, 16'h5A5A);

		// zero-length slots, all channels disabled, value_max lowered below stored
		apply_setup('{value_max: 15'd1, pulse_min: 16'd0, pulse_max: 16'd0,
			unit_q8: 16'hFFFF, frame_ticks: 16'd1, channel_enable: 8'h00});
		push_word(FUNC_TICK, 4'd0, 16'd0);
		push_word(FUNC_TICK, 4'd0, 16'd0);
		push_word(FUNC_ADD, 4'd0, 16'd0);

		// crossed limits filling the frame
		apply_setup('{value_max: 15'h7FFF, pulse_min: 16'd5, pulse_max: 16'd2,
			unit_q8: 16'd0, frame_ticks: 16'd40, channel_enable: 8'hA5});
		push_word(FUNC_SET, 4'd2, 16'h7FFF);
		run_to_recompute();
		push_word(FUNC_TICK, 4'd0, 16'd0);
		push_word(FUNC_TICK, 4'd0, 16'd0);

		// random phases with short frames
		for (int ph = 0; ph < 7; ph++) begin
			c.value_max      = ($urandom_range(0, 3) == 0) ? 15'h7FFF : 15'($urandom_range(1, 60));
			c.pulse_min      = 16'($urandom_range(0, 4));
			c.pulse_max      = 16'($urandom_range(0, 24));
			case ($urandom_range(0, 3))
				0:       c.unit_q8 = 16'd0;
				1:       c.unit_q8 = 16'hFFFF;
				default: c.unit_q8 = 16'($urandom_range(0, 600));
			endcase
			c.frame_ticks    = 16'($urandom_range(1, 150));
			c.channel_enable = 8'($urandom);
			apply_setup(c);
			sides_idle = ($urandom_range(0, 2) != 0);
			repeat (260) random_word();
		end

		// widest settings, no idling from here on
		sides_idle = 1'b0;
		apply_setup('{value_max: 15'h7FFF, pulse_min: 16'hFFFF, pulse_max: 16'hFFFF,
			unit_q8: 16'hFFFF, frame_ticks: 16'hFFFF, channel_enable: 8'hFF});
		push_word(FUNC_SET, 4'd0, 16'h7FFF);
		run_to_recompute();
		repeat (150) random_word();

		drain();
		repeat (40) @(negedge clk);
		if (sb.awaited.size() != 0)
			sb.report_mismatch($sformatf("%0d status words never came", sb.awaited.size()));
		if (sb.errors == 0) begin
			$display("multi_servo_pulse_sequencer_tb: PASS");
		end else begin
			$display("multi_servo_pulse_sequencer_tb: FAIL");
		end
		$finish;
	end

	// run limit
	initial begin
		#2_000_000;
		$display("multi_servo_pulse_sequencer_tb: FAIL");
		$finish;
	end

endmodule
